### sv/tmps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trimmed-mean pH scaler.
// Used by tmps_cell, tmps_scale and trimmed_mean_ph_scaler_core.
package tmps_pkg;

  // Configuration register indexes
  localparam logic REG_CAL_OFFSET = 1'b0;
  localparam logic REG_SLOPE_GAIN = 1'b1;

  // Register and field widths
  localparam int CFG_W   = 17;
  localparam int PH_W    = 17;
  localparam int TSUM_W  = 15;
  localparam int SAMP_W  = 12;

  localparam logic signed [CFG_W-1:0] CAL_OFFSET_RST = 17'sd0;
  localparam logic [CFG_W-1:0]        SLOPE_GAIN_RST = 17'd50160;

  // Saturation limits
  localparam int PH_MIN   = -65536;
  localparam int PH_MAX   = 65535;
  localparam int TSUM_MAX = 32767;

  // Control broadcast to every cell of the sort chain
  typedef struct packed {
    logic insert;  // place the new key in order
    logic drain;   // shift every cell one place toward cell 0
  } cell_ctrl_t;

endpackage

### sv/tmps_cell.sv
`timescale 1ns / 1ps
// One cell of the insertion-sort chain: holds one sample and a valid bit.
// Depends on tmps_pkg for the cell control struct.
module tmps_cell import tmps_pkg::*; #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] key,
  input  logic [W-1:0] lo_val,   // lower neighbor (smaller side)
  input  logic         lo_vld,
  input  logic         lo_gt,    // lower neighbor moves up on insert
  input  logic [W-1:0] hi_val,   // upper neighbor, used while draining
  input  logic         hi_vld,
  output logic [W-1:0] val,
  output logic         vld,
  output logic         gt
);

  // An empty cell counts as larger than any key
  assign gt = !vld || (val > key);

  // Insert in order, or shift toward cell 0 while draining
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.drain) begin
      val <= hi_val;
      vld <= hi_vld;
    end else if (ctrl.insert && gt) begin
      if (lo_gt) begin
        val <= lo_val;
        vld <= lo_vld;
      end else begin
        val <= key;
        vld <= 1'b1;
      end
    end
  end

endmodule

### sv/tmps_scale.sv
`timescale 1ns / 1ps
// Gain multiply, half-up rounding, offset subtract and saturation.
// Depends on tmps_pkg for widths and limits.
module tmps_scale import tmps_pkg::*; #(
  parameter int SUM_W = 16
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic [SUM_W-1:0]        sum,
  input  logic [CFG_W-1:0]        gain,
  input  logic signed [CFG_W-1:0] offset,
  output logic signed [PH_W-1:0]  ph_milli
);

  localparam int PROD_W = SUM_W + CFG_W;
  localparam int Q_W    = PROD_W + 1 - 16;
  localparam int D_W    = ((Q_W > CFG_W) ? Q_W : CFG_W) + 2;

  logic [PROD_W-1:0]     prod;
  logic [PROD_W:0]       rounded;
  logic [Q_W-1:0]        q;
  logic signed [D_W-1:0] off_ext;
  logic signed [D_W-1:0] q_ext;
  logic signed [D_W-1:0] diff;

  // Register the product before the rounding stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(sum) * PROD_W'(gain);
    end
  end

  // Round half up, subtract from the offset, clamp to the field range
  always_comb begin
    rounded = (PROD_W + 1)'(prod) + (PROD_W + 1)'(32768);
    q       = rounded[PROD_W:16];
    off_ext = D_W'(offset);
    q_ext   = $signed(D_W'(q));
    diff    = off_ext - q_ext;
    if (diff < D_W'(PH_MIN)) begin
      ph_milli = PH_W'(PH_MIN);
    end else if (diff > D_W'(PH_MAX)) begin
      ph_milli = PH_W'(PH_MAX);
    end else begin
      ph_milli = diff[PH_W-1:0];
    end
  end

endmodule

### sv/trimmed_mean_ph_scaler_core.sv
`timescale 1ns / 1ps
// Trimmed-mean pH scaler top level. Samples enter an insertion-sort cell chain
// at one beat per cycle while s_tready is high in S_FILL. After the last sample
// of a burst the chain drains in S_DRAIN, S_MUL registers the product and S_OUT
// loads the result beat once any earlier result beat is taken. s_tready stays
// low from S_DRAIN until S_OUT loads it; one burst is BURST_SAMPLES sample beats.
// Synchronous reset clears chain valid bits, fill count and m_tvalid; registers reset.
module trimmed_mean_ph_scaler_core import tmps_pkg::*; #(
  parameter int BURST_SAMPLES = 10,
  parameter int DROP_EACH_END = 2,
  parameter int ADC_BITS      = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // [11:0] sample
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // [16:0] ph_milli, [31:17] trimmed_sum
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int N     = BURST_SAMPLES;
  localparam int CNT_W = $clog2(N);
  localparam int SUM_W = ADC_BITS + $clog2(N);

  typedef enum logic [1:0] {S_FILL, S_DRAIN, S_MUL, S_OUT} state_t;

  state_t                  state;
  logic [CNT_W-1:0]        fill_count;
  logic [CNT_W-1:0]        drain_idx;
  logic [SUM_W-1:0]        acc;
  logic signed [CFG_W-1:0] cal_offset;
  logic [CFG_W-1:0]        slope_gain;
  logic signed [PH_W-1:0]  ph_out;
  logic [TSUM_W-1:0]       tsum_out;
  logic signed [PH_W-1:0]  ph_calc;
  logic [15:0]             samp16;
  logic [ADC_BITS-1:0]     key;
  logic                    in_beat;
  logic                    in_window;
  cell_ctrl_t              ctrl;

  logic [ADC_BITS-1:0] cval [N];
  logic                cvld [N];
  logic                cgt  [N];

  assign samp16   = {4'b0, s_tdata[SAMP_W-1:0]};
  assign key      = samp16[ADC_BITS-1:0];
  assign s_tready = (state == S_FILL);
  assign in_beat  = s_tvalid && s_tready;
  assign ctrl     = '{insert: in_beat, drain: (state == S_DRAIN)};
  assign m_tdata  = {tsum_out, ph_out};

  // Cell 0 holds the smallest sample
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic [ADC_BITS-1:0] lo_val;
      logic                lo_vld;
      logic                lo_gt;
      logic [ADC_BITS-1:0] hi_val;
      logic                hi_vld;
      if (i == 0) begin : g_lo_end
        assign lo_val = '0;
        assign lo_vld = 1'b0;
        assign lo_gt  = 1'b0;
      end else begin : g_lo
        assign lo_val = cval[i-1];
        assign lo_vld = cvld[i-1];
        assign lo_gt  = cgt[i-1];
      end
      if (i == N - 1) begin : g_hi_end
        assign hi_val = '0;
        assign hi_vld = 1'b0;
      end else begin : g_hi
        assign hi_val = cval[i+1];
        assign hi_vld = cvld[i+1];
      end
      tmps_cell #(.W(ADC_BITS)) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (ctrl),
        .key    (key),
        .lo_val (lo_val),
        .lo_vld (lo_vld),
        .lo_gt  (lo_gt),
        .hi_val (hi_val),
        .hi_vld (hi_vld),
        .val    (cval[i]),
        .vld    (cvld[i]),
        .gt     (cgt[i])
      );
    end
  endgenerate

  tmps_scale #(.SUM_W(SUM_W)) u_scale (
    .clk      (clk),
    .load     (state == S_MUL),
    .sum      (acc),
    .gain     (slope_gain),
    .offset   (cal_offset),
    .ph_milli (ph_calc)
  );

  // Ordered rank leaving cell 0 lies between the trimmed ends
  assign in_window = (int'(drain_idx) >= DROP_EACH_END) &&
                     (int'(drain_idx) + DROP_EACH_END < N);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= CAL_OFFSET_RST;
      slope_gain <= SLOPE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_OFFSET: cal_offset <= $signed(cfg_data);
        REG_SLOPE_GAIN: slope_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence fill, drain, multiply and output; hold the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_count <= '0;
      drain_idx  <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop a taken beat; the output state sets valid itself
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_FILL: begin
          if (in_beat) begin
            if (int'(fill_count) == N - 1) begin
              fill_count <= '0;
              drain_idx  <= '0;
              acc        <= '0;
              state      <= S_DRAIN;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
          end
        end
        S_DRAIN: begin
          if (in_window) begin
            acc <= acc + SUM_W'(cval[0]);
          end
          if (int'(drain_idx) == N - 1) begin
            state <= S_MUL;
          end else begin
            drain_idx <= drain_idx + 1'b1;
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            ph_out   <= ph_calc;
            tsum_out <= (acc > SUM_W'(TSUM_MAX)) ? TSUM_W'(TSUM_MAX) : acc[TSUM_W-1:0];
            m_tvalid <= 1'b1;
            state    <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule
